// ----- sv/query_string_pair_decoder_defines.svh -----
// assertion macros for the query string pair decoder
// no dependencies; taken in by the modules that assert
`ifndef QUERY_STRING_PAIR_DECODER_DEFINES_SVH
`define QUERY_STRING_PAIR_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define QSPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define QSPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/qspd_pkg.sv -----
// types, character codes and hex helpers for the query string pair decoder
// no dependencies
package qspd_pkg;

    localparam int BYTE_W    = 8;
    localparam int NIBBLE_W  = 4;
    localparam int MAX_RES   = 3;
    localparam int RES_CNT_W = 2;

    localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [BYTE_W-1:0] CH_W     = 8'h57;  // 'W', 'a' minus ten
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h66;
    localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,  // no escape pending
        ESC_PCT   = 2'd1,  // '%' seen
        ESC_DIGIT = 2'd2   // '%' and one hex digit seen
    } t_esc;

    typedef struct packed {
        logic              value_phase;
        t_esc              esc;
        logic [BYTE_W-1:0] held;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              in_value;
        logic              pair_end;
        logic              run_last;
    } t_result;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [NIBBLE_W-1:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        d = (c <= CH_NINE) ? (c - CH_ZERO) : ((c | CASE_BIT) - CH_W);
        return d[NIBBLE_W-1:0];
    endfunction

    function automatic t_result make_result(input logic [BYTE_W-1:0] b,
                                            input logic valid, input logic inval);
        t_result r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.in_value   = inval;
        r.pair_end   = 1'b0;
        r.run_last   = 1'b0;
        return r;
    endfunction

endpackage

// ----- sv/qspd_if.sv -----
// valid/ready channel interfaces for the query string pair decoder
// depends on qspd_pkg for the byte width
interface qspd_in_if;
    logic                        valid;
    logic                        ready;
    logic [qspd_pkg::BYTE_W-1:0] in_byte;
    logic                        in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qspd_out_if;
    logic                        valid;
    logic                        ready;
    logic [qspd_pkg::BYTE_W-1:0] out_byte;
    logic                        byte_valid;
    logic                        in_value;
    logic                        pair_end;
    logic                        run_last;

    modport source (output valid, output out_byte, output byte_valid, output in_value,
                    output pair_end, output run_last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input in_value,
                    input pair_end, input run_last, output ready);
endinterface

// ----- sv/qspd_decode.sv -----
// per-character decode: next parser state and up to three result items
// depends on qspd_pkg
module qspd_decode (
    input  logic [qspd_pkg::BYTE_W-1:0]    i_byte,
    input  logic                           i_last,
    input  logic                           i_plus,
    input  qspd_pkg::t_state               i_state,
    output qspd_pkg::t_state               o_state,
    output qspd_pkg::t_result              o_res [qspd_pkg::MAX_RES],
    output logic [qspd_pkg::RES_CNT_W-1:0] o_count
);
    import qspd_pkg::*;

    logic                 sep;
    logic                 hexb;
    logic                 end_pair;
    t_state               st;
    t_result              res [MAX_RES];
    logic [RES_CNT_W-1:0] cnt;

    always_comb begin
        sep      = (i_byte == CH_AMP);
        hexb     = is_hex(i_byte);
        end_pair = sep || i_last;
        st       = i_state;
        cnt      = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end

        if (!sep) begin
            if (!st.value_phase) begin
                if (i_byte == CH_EQ) begin
                    st.value_phase = 1'b1;
                end else begin
                    res[cnt] = make_result(i_byte, 1'b1, 1'b0);
                    cnt      = cnt + 2'd1;
                end
            end else if (st.esc == ESC_PCT && hexb) begin
                st.held = i_byte;
                st.esc  = ESC_DIGIT;
            end else if (st.esc == ESC_DIGIT && hexb) begin
                res[cnt] = make_result({hex_val(st.held), hex_val(i_byte)}, 1'b1, 1'b1);
                cnt      = cnt + 2'd1;
                st.esc   = ESC_IDLE;
            end else begin
                // broken escape goes out literally, then the byte starts afresh
                if (st.esc != ESC_IDLE) begin
                    res[cnt] = make_result(CH_PCT, 1'b1, 1'b1);
                    cnt      = cnt + 2'd1;
                end
                if (st.esc == ESC_DIGIT) begin
                    res[cnt] = make_result(st.held, 1'b1, 1'b1);
                    cnt      = cnt + 2'd1;
                end
                st.esc = ESC_IDLE;
                if (i_byte == CH_PCT) begin
                    st.esc = ESC_PCT;
                end else if (i_plus && i_byte == CH_PLUS) begin
                    res[cnt] = make_result(CH_SPACE, 1'b1, 1'b1);
                    cnt      = cnt + 2'd1;
                end else begin
                    res[cnt] = make_result(i_byte, 1'b1, 1'b1);
                    cnt      = cnt + 2'd1;
                end
            end
        end

        if (end_pair) begin
            // flush a pending escape at the end of the pair
            if (st.esc != ESC_IDLE) begin
                res[cnt] = make_result(CH_PCT, 1'b1, 1'b1);
                cnt      = cnt + 2'd1;
            end
            if (st.esc == ESC_DIGIT) begin
                res[cnt] = make_result(st.held, 1'b1, 1'b1);
                cnt      = cnt + 2'd1;
            end
            // bare pair end when nothing else came out
            if (cnt == '0) begin
                res[cnt] = make_result('0, 1'b0, st.value_phase);
                cnt      = cnt + 2'd1;
            end
            st = '0;
        end

        if (cnt != '0) begin
            res[cnt - 2'd1].pair_end = end_pair;
            res[cnt - 2'd1].run_last = 1'b1;
        end
    end

    assign o_state = st;
    assign o_count = cnt;
    assign o_res   = res;

endmodule

// ----- sv/query_string_pair_decoder.sv -----
// query string pair decoder top level: parser state, result buffer, handshakes
// depends on qspd_pkg, qspd_if, qspd_decode and query_string_pair_decoder_defines.svh
//
// usage
//   i_in carries one query string character per item (in_byte) with in_last on
//   the final character. o_out carries result items: name bytes (in_value 0),
//   decoded value bytes (in_value 1), and pair_end on the item that closes a
//   pair; a pair with no byte left to carry it closes with a bare item
//   (byte_valid 0). run_last flags the final result of each input character.
//   i_cfg_we / i_cfg_data write plus_as_space ('+' in values becomes a space).
//   results of a character taken from i_in are registered into the buffer
//   and shown on o_out from its head. throughput: one item per cycle while
//   each character makes at most one result and o_out.ready stays high; a
//   character that makes more results (up to three, when an escape is
//   flushed) holds the output buffer until they have all left, since the
//   buffer is three deep and refilled only as its last result leaves; a
//   character with no result ('=', first escape digit) leaves it empty.
//   reset: synchronous, active low; clears the parser state, the buffer count and
//   plus_as_space. a stalled receiver holds the buffer, and i_in.ready stays
//   low until its last pending result is taken.
module query_string_pair_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qspd_in_if.sink    i_in,
    qspd_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);
    import qspd_pkg::*;
    `include "query_string_pair_decoder_defines.svh"

    // configuration
    logic                 r_plus_as_space;

    // parser state carried between characters
    t_state               r_state;
    t_state               n_state;

    // result buffer: slot 0 is the head shown on o_out
    t_result              r_slot [MAX_RES];
    logic [RES_CNT_W-1:0] r_rem;
    t_result              dec_res [MAX_RES];
    logic [RES_CNT_W-1:0] dec_count;

    logic                 in_take;
    logic                 out_take;

    qspd_decode u_decode (
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .i_plus  (r_plus_as_space),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (dec_res),
        .o_count (dec_count)
    );

    // take a character when the buffer is empty or drains its last result now
    assign i_in.ready = (r_rem == '0) || (r_rem == 2'd1 && o_out.ready);
    assign in_take    = i_in.valid && i_in.ready;
    assign out_take   = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_as_space <= 1'b0;
        end else if (i_cfg_we) begin
            r_plus_as_space <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (in_take) begin
            r_rem <= dec_count;
        end else if (out_take) begin
            r_rem <= r_rem - 2'd1;
        end
    end

    // buffer payload: load on a new character, shift toward the head on a take
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_slot <= dec_res;
        end else if (out_take) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_slot[k] <= r_slot[k + 1];
            end
        end
    end

    assign o_out.valid      = (r_rem != '0);
    assign o_out.out_byte   = r_slot[0].out_byte;
    assign o_out.byte_valid = r_slot[0].byte_valid;
    assign o_out.in_value   = r_slot[0].in_value;
    assign o_out.pair_end   = r_slot[0].pair_end;
    assign o_out.run_last   = r_slot[0].run_last;

    // a character is never taken over results still pending behind the head
    `QSPD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, in_take,
        r_rem == '0 || (r_rem == 2'd1 && out_take), "character taken over pending results")

    // the final character leaves the parser back in the name part, no escape
    `QSPD_ASSERT_NXT(a_state_cleared, i_clk, i_rst_n, in_take && i_in.in_last,
        !r_state.value_phase && r_state.esc == ESC_IDLE, "state not cleared after last")

    // the last pending result of a character carries run_last
    `QSPD_ASSERT_IMP(a_run_last, i_clk, i_rst_n, r_rem == 2'd1,
        r_slot[0].run_last, "last pending result lacks run_last")

    // a bare result only closes a pair and carries a zero byte
    `QSPD_ASSERT_IMP(a_bare_end, i_clk, i_rst_n, o_out.valid && !o_out.byte_valid,
        o_out.pair_end && o_out.out_byte == '0, "bare result malformed")

endmodule
